FILE: rtl/core/ucfs_pkg.sv
package ucfs_pkg;

   localparam int KEY_BITS   = 16;
   localparam int COUNT_BITS = 32;
   localparam int LEN_BITS   = 16;
   localparam int CNT_BITS   = 32;
   localparam int SUM_BITS   = 48;
   localparam int SQ_BITS    = 64;
   localparam int MEAN_BITS  = 24;
   localparam int VAR_BITS   = 48;
   localparam int WIDE_BITS  = 128;
   localparam int STEP_BITS  = $clog2(WIDE_BITS);

   // request actions
   localparam logic [2:0] ACT_LOAD   = 3'd0;
   localparam logic [2:0] ACT_BYTE   = 3'd1;
   localparam logic [2:0] ACT_LINE   = 3'd2;
   localparam logic [2:0] ACT_READ   = 3'd3;
   localparam logic [2:0] ACT_REPORT = 3'd4;
   localparam logic [2:0] ACT_CLEAR  = 3'd5;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  text_byte;
      logic [15:0] char_key;
      logic [1:0]  char_grade;
   } req_type;

   typedef struct packed {
      logic [31:0] char_count;
      logic [1:0]  grade_out;
      logic [31:0] sentence_total;
      logic [23:0] mean_q8;
      logic [47:0] variance_q8;
   } rsp_type;

   typedef struct packed {
      logic [MEAN_BITS-1:0] mean;
      logic [VAR_BITS-1:0]  variance;
   } stats_result_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_CHAR,
      ST_READ,
      ST_STATS
   } ctrl_state_type;

   typedef enum logic [2:0] {
      SS_IDLE,
      SS_MEAN,
      SS_MUL,
      SS_ACC,
      SS_DIV1,
      SS_DIV2
   } stats_state_type;

   // full-width and other punctuation that closes a sentence
   function automatic logic is_stop(input logic [15:0] code);
      logic hit;
      hit = (code == 16'hFF0C) || (code == 16'h3002) || (code == 16'hFF01) ||
            (code == 16'hFF1F) || (code == 16'hFF1B) || (code == 16'hFF1A) ||
            (code == 16'h2026) || (code == 16'hFE54) || (code == 16'hFE55);
      return hit;
   endfunction

endpackage

FILE: rtl/core/ucfs_stats.sv
module ucfs_stats (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [ucfs_pkg::CNT_BITS-1:0]      count,
   input  logic [ucfs_pkg::SUM_BITS-1:0]      sum,
   input  logic [ucfs_pkg::SQ_BITS-1:0]       square_sum,
   output logic                               busy,
   output ucfs_pkg::stats_result_type         result
);

   localparam int W = ucfs_pkg::WIDE_BITS;

   ucfs_pkg::stats_state_type state_ff, state_in;
   logic [ucfs_pkg::CNT_BITS-1:0]  n_ff, n_in;
   logic [ucfs_pkg::SUM_BITS-1:0]  s_ff, s_in;
   logic [ucfs_pkg::SQ_BITS-1:0]   sq_ff, sq_in;
   logic [W-1:0]                   quo_ff, quo_in;
   logic [31:0]                    rem_ff, rem_in;
   logic [ucfs_pkg::STEP_BITS-1:0] cnt_ff, cnt_in;
   logic [2:0]                     step_ff, step_in;
   logic [63:0]                    prod_ff, prod_in;
   logic [W-1:0]                   acc_ff, acc_in;
   ucfs_pkg::stats_result_type     res_ff, res_in;

   logic [32:0]  div_t;
   logic         div_ge;
   logic [32:0]  div_diff;
   logic [31:0]  rem_step;
   logic [W-1:0] quo_step;
   logic [31:0]  op_a, op_b;
   logic [2:0]   term_sel;
   logic [W-1:0] term;
   logic [W-1:0] acc_next;

   // one restoring division step per cycle
   always_comb begin
      div_t    = {rem_ff, quo_ff[W-1]};
      div_ge   = div_t >= {1'b0, n_ff};
      div_diff = div_t - {1'b0, n_ff};
      rem_step = div_ge ? div_diff[31:0] : div_t[31:0];
      quo_step = {quo_ff[W-2:0], div_ge};
   end

   // pick the partial product operands of n*sq - s*s
   always_comb begin
      unique case (step_ff)
         3'd0: begin op_a = n_ff; op_b = sq_ff[31:0]; end
         3'd1: begin op_a = n_ff; op_b = sq_ff[63:32]; end
         3'd2: begin op_a = s_ff[31:0]; op_b = s_ff[31:0]; end
         3'd3: begin op_a = s_ff[31:0]; op_b = {16'd0, s_ff[47:32]}; end
         default: begin op_a = {16'd0, s_ff[47:32]}; op_b = {16'd0, s_ff[47:32]}; end
      endcase
   end

   // weigh the registered product and fold it into the accumulator
   always_comb begin
      term_sel = (state_ff == ucfs_pkg::SS_ACC) ? 3'd4 : (step_ff - 3'd1);
      unique case (term_sel)
         3'd0:    term = {64'd0, prod_ff};
         3'd1:    term = {64'd0, prod_ff} << 32;
         3'd2:    term = {64'd0, prod_ff};
         3'd3:    term = {64'd0, prod_ff} << 33;
         default: term = {64'd0, prod_ff} << 64;
      endcase
      if (term_sel == 3'd0 || term_sel == 3'd1) begin
         acc_next = acc_ff + term;
      end else begin
         acc_next = acc_ff - term;
      end
   end

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      s_in     = s_ff;
      sq_in    = sq_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      step_in  = step_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;
      unique case (state_ff)
         ucfs_pkg::SS_IDLE: begin
            if (start) begin
               n_in  = count;
               s_in  = sum;
               sq_in = square_sum;
               if (count == '0) begin
                  res_in = '0;
               end else begin
                  quo_in   = {{(W-ucfs_pkg::SUM_BITS-8){1'b0}}, sum, 8'd0};
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = ucfs_pkg::SS_MEAN;
               end
            end
         end
         ucfs_pkg::SS_MEAN: begin
            quo_in = quo_step;
            rem_in = rem_step;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               res_in.mean = quo_step[ucfs_pkg::MEAN_BITS-1:0];
               step_in     = '0;
               acc_in      = '0;
               state_in    = ucfs_pkg::SS_MUL;
            end
         end
         ucfs_pkg::SS_MUL: begin
            prod_in = op_a * op_b;
            if (step_ff != 3'd0) begin
               acc_in = acc_next;
            end
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd4) begin
               state_in = ucfs_pkg::SS_ACC;
            end
         end
         ucfs_pkg::SS_ACC: begin
            quo_in   = {acc_next[W-9:0], 8'd0};
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ucfs_pkg::SS_DIV1;
         end
         ucfs_pkg::SS_DIV1: begin
            quo_in = quo_step;
            rem_in = rem_step;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               rem_in   = '0;
               state_in = ucfs_pkg::SS_DIV2;
            end
         end
         ucfs_pkg::SS_DIV2: begin
            quo_in = quo_step;
            rem_in = rem_step;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               res_in.variance = quo_step[ucfs_pkg::VAR_BITS-1:0];
               state_in        = ucfs_pkg::SS_IDLE;
            end
         end
         default: state_in = ucfs_pkg::SS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ucfs_pkg::SS_IDLE;
         cnt_ff   <= '0;
         step_ff  <= '0;
         res_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         step_ff  <= step_in;
         res_ff   <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      s_ff    <= s_in;
      sq_ff   <= sq_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign busy   = state_ff != ucfs_pkg::SS_IDLE;
   assign result = res_ff;

endmodule

FILE: rtl/core/utf8_char_frequency_sentence_stats.sv
// Character frequency and sentence-length statistics over a UTF-8 byte stream, with
// the grade and frequency tables held in two single-port synchronous memories of
// 2^KEY_BITS entries. Line ends and text bytes that do not complete a counted
// character are handled in the idle state; a level load and a well-formed character
// other than a stop code take a memory read, then a write-back; a read takes a memory
// read plus any wait for the result register to drain; a report waits on the shared
// one-bit-per-cycle divider (three 128-step divisions: mean, then the variance twice
// by the count) and a five-step 32x32 multiply sequence. After reset a clearing pass
// sweeps both memories, and a clear request the frequency memory only, one entry a
// cycle over all 2^KEY_BITS entries; no request is taken during the pass.
module utf8_char_frequency_sentence_stats (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ucfs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ucfs_pkg::rsp_type rsp_data
);

   localparam int KB = ucfs_pkg::KEY_BITS;
   localparam int CB = ucfs_pkg::COUNT_BITS;
   localparam int LB = ucfs_pkg::LEN_BITS;

   logic [CB-1:0] freq_mem  [0:(1<<KB)-1];
   logic [1:0]    grade_mem [0:(1<<KB)-1];

   ucfs_pkg::ctrl_state_type state_ff, state_in;
   logic [1:0]                    pending_ff, pending_in;
   logic [15:0]                   held_ff, held_in;
   logic [LB-1:0]                 cur_len_ff, cur_len_in;
   logic [ucfs_pkg::CNT_BITS-1:0] sent_cnt_ff, sent_cnt_in;
   logic [ucfs_pkg::SUM_BITS-1:0] len_sum_ff, len_sum_in;
   logic [ucfs_pkg::SQ_BITS-1:0]  len_sq_ff, len_sq_in;
   logic [KB-1:0]                 key_ff, key_in;
   logic [1:0]                    grade_ld_ff, grade_ld_in;
   logic                          key_ok_ff, key_ok_in;
   logic [KB-1:0]                 clr_addr_ff, clr_addr_in;
   logic                          clr_all_ff, clr_all_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   ucfs_pkg::rsp_type             rsp_data_ff, rsp_data_in;
   logic [CB-1:0]                 freq_rd_ff;
   logic [1:0]                    grade_rd_ff;

   logic          accept;
   logic          slot_free;
   logic          mem_rd_en;
   logic [KB-1:0] mem_addr;
   logic          freq_we, grade_we;
   logic [CB-1:0] freq_wd;
   logic [1:0]    grade_wd;
   logic          close_en;
   logic          stats_start;
   logic          stats_busy;
   ucfs_pkg::stats_result_type stats_res;
   logic [15:0]   char_code;
   logic          char_ok;
   logic          req_key_ok;
   logic          char_key_ok;
   logic [31:0]   len_square;

   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // assemble the code of the held character with the closing byte
   always_comb begin
      char_code = {held_ff[11:8], held_ff[5:0], req_data.text_byte[5:0]};
      char_ok   = (held_ff[15:12] == 4'hE) && (held_ff[7:6] == 2'b10) &&
                  (req_data.text_byte[7:6] == 2'b10);
      req_key_ok  = ({16'd0, req_data.char_key} >> KB) == 32'd0;
      char_key_ok = ({16'd0, char_code} >> KB) == 32'd0;
      len_square  = {16'd0, cur_len_ff} * {16'd0, cur_len_ff};
   end

   always_comb begin
      state_in     = state_ff;
      pending_in   = pending_ff;
      held_in      = held_ff;
      cur_len_in   = cur_len_ff;
      sent_cnt_in  = sent_cnt_ff;
      len_sum_in   = len_sum_ff;
      len_sq_in    = len_sq_ff;
      key_in       = key_ff;
      grade_ld_in  = grade_ld_ff;
      key_ok_in    = key_ok_ff;
      clr_addr_in  = clr_addr_ff;
      clr_all_in   = clr_all_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_rd_en    = 1'b0;
      mem_addr     = req_data.char_key[KB-1:0];
      freq_we      = 1'b0;
      grade_we     = 1'b0;
      freq_wd      = '0;
      grade_wd     = '0;
      close_en     = 1'b0;
      stats_start  = 1'b0;
      req_ready    = 1'b0;
      unique case (state_ff)
         ucfs_pkg::ST_CLEAR: begin
            // sweep one entry a cycle
            mem_addr    = clr_addr_ff;
            freq_we     = 1'b1;
            grade_we    = clr_all_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               state_in = ucfs_pkg::ST_IDLE;
            end
         end
         ucfs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               unique case (req_data.action)
                  ucfs_pkg::ACT_LOAD: begin
                     mem_rd_en   = 1'b1;
                     key_in      = req_data.char_key[KB-1:0];
                     grade_ld_in = req_data.char_grade;
                     if (req_key_ok) begin
                        state_in = ucfs_pkg::ST_LOAD;
                     end
                  end
                  ucfs_pkg::ACT_BYTE: begin
                     unique case (pending_ff)
                        2'd0: begin
                           if (req_data.text_byte >= 8'hE0) begin
                              held_in    = {req_data.text_byte, 8'd0};
                              pending_in = 2'd2;
                           end
                        end
                        2'd2: begin
                           held_in    = {held_ff[15:8], req_data.text_byte};
                           pending_in = 2'd1;
                        end
                        default: begin
                           pending_in = 2'd0;
                           if (char_ok) begin
                              if (ucfs_pkg::is_stop(char_code)) begin
                                 close_en = 1'b1;
                              end else if (char_key_ok) begin
                                 mem_rd_en = 1'b1;
                                 mem_addr  = char_code[KB-1:0];
                                 key_in    = char_code[KB-1:0];
                                 state_in  = ucfs_pkg::ST_CHAR;
                              end
                           end
                        end
                     endcase
                  end
                  ucfs_pkg::ACT_LINE: begin
                     pending_in = 2'd0;
                     held_in    = '0;
                     close_en   = 1'b1;
                  end
                  ucfs_pkg::ACT_READ: begin
                     mem_rd_en = 1'b1;
                     key_ok_in = req_key_ok;
                     state_in  = ucfs_pkg::ST_READ;
                  end
                  ucfs_pkg::ACT_REPORT: begin
                     stats_start = 1'b1;
                     state_in    = ucfs_pkg::ST_STATS;
                  end
                  ucfs_pkg::ACT_CLEAR: begin
                     pending_in  = 2'd0;
                     held_in     = '0;
                     cur_len_in  = '0;
                     sent_cnt_in = '0;
                     len_sum_in  = '0;
                     len_sq_in   = '0;
                     clr_addr_in = '0;
                     clr_all_in  = 1'b0;
                     state_in    = ucfs_pkg::ST_CLEAR;
                  end
                  default: ;
               endcase
            end
         end
         ucfs_pkg::ST_LOAD: begin
            // keep the first level written
            mem_addr = key_ff;
            grade_wd = grade_ld_ff;
            grade_we = (grade_rd_ff == 2'd0) && (grade_ld_ff != 2'd0);
            state_in = ucfs_pkg::ST_IDLE;
         end
         ucfs_pkg::ST_CHAR: begin
            // raise frequency and sentence length of a graded character
            mem_addr = key_ff;
            freq_wd  = (freq_rd_ff == '1) ? freq_rd_ff : freq_rd_ff + 1'b1;
            if (grade_rd_ff != 2'd0) begin
               freq_we = 1'b1;
               if (cur_len_ff != '1) begin
                  cur_len_in = cur_len_ff + 1'b1;
               end
            end
            state_in = ucfs_pkg::ST_IDLE;
         end
         ucfs_pkg::ST_READ: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               if (key_ok_ff) begin
                  rsp_data_in.char_count = 32'(freq_rd_ff);
                  rsp_data_in.grade_out  = grade_rd_ff;
               end
               state_in = ucfs_pkg::ST_IDLE;
            end
         end
         ucfs_pkg::ST_STATS: begin
            if (!stats_busy && slot_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in                = '0;
               rsp_data_in.sentence_total = sent_cnt_ff;
               rsp_data_in.mean_q8        = stats_res.mean;
               rsp_data_in.variance_q8    = stats_res.variance;
               state_in                   = ucfs_pkg::ST_IDLE;
            end
         end
         default: state_in = ucfs_pkg::ST_IDLE;
      endcase

      // close the current sentence and record it if non-empty and the sentence count is not saturated
      if (close_en) begin
         cur_len_in = '0;
         if (cur_len_ff != '0 && sent_cnt_ff != '1) begin
            sent_cnt_in = sent_cnt_ff + 1'b1;
            len_sum_in  = len_sum_ff + {{(ucfs_pkg::SUM_BITS-LB){1'b0}}, cur_len_ff};
            len_sq_in   = len_sq_ff + {32'd0, len_square};
         end
      end
   end

   // memories: one access per cycle, registered read data
   always_ff @(posedge clock) begin
      if (freq_we) begin
         freq_mem[mem_addr] <= freq_wd;
      end
      if (grade_we) begin
         grade_mem[mem_addr] <= grade_wd;
      end
      if (mem_rd_en) begin
         freq_rd_ff  <= freq_mem[mem_addr];
         grade_rd_ff <= grade_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ucfs_pkg::ST_CLEAR;
         pending_ff   <= '0;
         held_ff      <= '0;
         cur_len_ff   <= '0;
         sent_cnt_ff  <= '0;
         len_sum_ff   <= '0;
         len_sq_ff    <= '0;
         clr_addr_ff  <= '0;
         clr_all_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         held_ff      <= held_in;
         cur_len_ff   <= cur_len_in;
         sent_cnt_ff  <= sent_cnt_in;
         len_sum_ff   <= len_sum_in;
         len_sq_ff    <= len_sq_in;
         clr_addr_ff  <= clr_addr_in;
         clr_all_ff   <= clr_all_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      grade_ld_ff <= grade_ld_in;
      key_ok_ff   <= key_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   ucfs_stats u_stats (
      .clock      (clock),
      .reset      (reset),
      .start      (stats_start),
      .count      (sent_cnt_ff),
      .sum        (len_sum_ff),
      .square_sum (len_sq_ff),
      .busy       (stats_busy),
      .result     (stats_res)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // no request is taken during the clearing pass
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ucfs_pkg::ST_CLEAR |-> !req_ready)
      else $error("request taken while clearing");

   // an accepted report with a non-zero sentence count starts the statistics unit
   a_report_starts: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.action == ucfs_pkg::ACT_REPORT && sent_cnt_ff != '0 |=> stats_busy)
      else $error("report did not start statistics");

   // the byte assembler never holds an impossible count
   a_pending_range: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("pending byte count out of range");

   // a stalled result is not overwritten
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("stalled result changed");

endmodule
